// ===== hw/rtl/bpa_pkg.sv =====
// Shared constants and types for the bitmap page allocator.
// No dependencies; imported by bpa_word_search and the top level.
`default_nettype none

package bpa_pkg;

    localparam int NUM_PAGES = 1024;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int CNT_W     = PAGE_W + 1;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int NUM_WORDS = NUM_PAGES / WORD_W;
    localparam int ROW_W     = $clog2(NUM_WORDS);
    localparam int MODE_W    = 2;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = ((PAGE_W + CNT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((1 + PAGE_W + CNT_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_MARK  = 2'd2,
        MODE_RSVD  = 2'd3
    } t_mode;

    // outcome of searching one map word for a free run
    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] pos;
        logic [CNT_W-1:0] carry;
    } t_srch;

endpackage

`default_nettype wire

// ===== hw/rtl/bpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bpa_word_search.sv =====
// Free-run search across one used-map word, carrying the run length in from the
// previous word. Depends on bpa_pkg.
`default_nettype none

module bpa_word_search (
    input  wire logic [bpa_pkg::WORD_W-1:0] i_word,   // 1 = page used
    input  wire logic [bpa_pkg::BIT_W-1:0]  i_lo,     // bits below this count as used
    input  wire logic [bpa_pkg::CNT_W-1:0]  i_carry,  // free run ending at previous word
    input  wire logic [bpa_pkg::CNT_W-1:0]  i_len,
    output bpa_pkg::t_srch                  o_srch
);
    import bpa_pkg::*;

    logic [WORD_W-1:0] w_used;
    logic [CNT_W-1:0]  w_tot [WORD_W];
    logic [WORD_W-1:0] w_hitv;
    logic              w_found;
    logic [BIT_W-1:0]  w_uidx;

    // free run length ending at each bit: distance to the nearest used bit
    // at or below it, or the whole prefix plus the carried run
    always_comb begin
        w_used = i_word | ((WORD_W'(1) << i_lo) - WORD_W'(1));
        for (int j = 0; j < WORD_W; j++) begin
            w_found = 1'b0;
            w_uidx  = '0;
            for (int i = 0; i <= j; i++) begin
                if (w_used[i]) begin
                    w_found = 1'b1;
                    w_uidx  = BIT_W'(i);
                end
            end
            w_tot[j]  = w_found ? (CNT_W'(j) - CNT_W'(w_uidx))
                                : (i_carry + CNT_W'(j + 1));
            w_hitv[j] = !w_used[j] && (w_tot[j] >= i_len);
        end
    end

    // lowest bit where the run first reaches the requested length
    always_comb begin
        o_srch.hit   = 1'b0;
        o_srch.pos   = '0;
        o_srch.carry = w_tot[WORD_W-1];
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (w_hitv[j]) begin
                o_srch.hit = 1'b1;
                o_srch.pos = BIT_W'(j);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_page_allocator_top.sv =====
// Top level of the next-fit bitmap page allocator: request sequencer, used map
// RAM with per-row valid bits and output register. Depends on bpa_pkg, bpa_ram,
// bpa_word_search.
//
// Usage:
//   Requests arrive on the s-side stream: tuser carries the mode (allocate,
//   free, mark used), tdata the start page and the page count. Each request
//   gives exactly one response beat on the m-side stream: ok, base page and
//   pages granted.
//   The used map sits in a 32 x 32-bit RAM with a registered read. An
//   allocate streams the map one word per cycle from the next-fit pointer
//   to the map end, repeats once from page zero on a miss unless the
//   pointer was already zero, then read-modify-writes one word per cycle
//   over the run it grants. Free and mark used read-modify-write each map
//   word their range touches; a zero-page or unused-mode request answers
//   without touching the map. One request is in flight at a time; the word
//   search and the RAM read port set the pace.
//   Reset clears the row valid bits, so every page reads as used at once,
//   and zeroes the pointer; no clearing pass is needed.
//   When the receiver stalls, the response waits in the output register and
//   the next request is still taken; its response waits behind the first.
`default_nettype none

module bitmap_page_allocator_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata: start_page, page_count, zero pad
    input  wire logic [bpa_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // tuser: mode
    input  wire logic [bpa_pkg::MODE_W-1:0]      i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // tdata: ok, base_page, granted_pages, zero pad
    output logic      [bpa_pkg::M_TDATA_W-1:0]   o_m_tdata
);
    import bpa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FILL = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_WORDS - 1);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_ptr;
    logic [NUM_WORDS-1:0] r_row_vld;
    logic               r_out_vld;
    logic               r_ev_vld;

    logic               r_is_alloc;
    logic [CNT_W-1:0]   r_count;
    logic [ROW_W-1:0]   r_rd_row;
    logic [ROW_W-1:0]   r_ev_row;
    logic               r_ev_first;
    logic [CNT_W-1:0]   r_carry;
    logic [BIT_W-1:0]   r_lo;
    logic               r_q_vld;
    logic [PAGE_W-1:0]  r_f_start;
    logic [PAGE_W-1:0]  r_f_last;
    logic               r_f_val;
    logic               r_res_ok;
    logic [PAGE_W-1:0]  r_res_base;
    logic [CNT_W-1:0]   r_res_gr;
    logic               r_out_ok;
    logic [PAGE_W-1:0]  r_out_base;
    logic [CNT_W-1:0]   r_out_gr;

    logic               w_accept;
    t_mode              w_mode;
    logic [PAGE_W-1:0]  w_in_start;
    logic [CNT_W-1:0]   w_in_count;
    logic [CNT_W:0]     w_end_sum;
    logic [CNT_W-1:0]   w_end_c;
    logic [CNT_W-1:0]   w_in_gr;
    logic [CNT_W-1:0]   w_in_last;

    logic [WORD_W-1:0]  w_q;
    logic [WORD_W-1:0]  w_word;
    t_srch              w_srch;
    logic [CNT_W-1:0]   w_hit_base;
    logic [CNT_W-1:0]   w_hit_last;
    logic               w_scan_hit;
    logic               w_scan_end;
    logic               w_retry;
    logic               w_fill_end;
    logic               w_out_free;

    logic               w_we;
    logic [BIT_W-1:0]   w_lo_b;
    logic [BIT_W-1:0]   w_hi_b;
    logic [WORD_W-1:0]  w_mask;
    logic [WORD_W-1:0]  w_wdata;

    // request decode
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_mode     = t_mode'(i_s_tuser);
    assign w_in_start = i_s_tdata[PAGE_W-1:0];
    assign w_in_count = i_s_tdata[PAGE_W +: CNT_W];
    assign w_end_sum  = {2'b00, w_in_start} + {1'b0, w_in_count};
    assign w_end_c    = (w_end_sum > (CNT_W + 1)'(NUM_PAGES)) ? CNT_W'(NUM_PAGES)
                                                              : w_end_sum[CNT_W-1:0];
    assign w_in_gr    = w_end_c - {1'b0, w_in_start};
    assign w_in_last  = w_end_c - CNT_W'(1);

    // map RAM; a row never written reads as all used
    bpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_ev_row),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_row),
        .o_rdata (w_q)
    );

    assign w_word = r_q_vld ? w_q : '1;

    bpa_word_search u_search (
        .i_word  (w_word),
        .i_lo    (r_ev_first ? r_lo : '0),
        .i_carry (r_carry),
        .i_len   (r_count),
        .o_srch  (w_srch)
    );

    // the run ends exactly at the hit bit, so its base is hit - len + 1
    assign w_hit_base = {1'b0, r_ev_row, w_srch.pos} + CNT_W'(1) - r_count;
    assign w_hit_last = {1'b0, r_ev_row, w_srch.pos};

    assign w_scan_hit = (r_state == S_SCAN) && r_ev_vld && w_srch.hit;
    assign w_scan_end = (r_state == S_SCAN) && r_ev_vld && !w_srch.hit
                        && (r_ev_row == LAST_ROW);
    assign w_retry    = w_scan_end && (r_ptr != '0);
    assign w_fill_end = (r_state == S_FILL) && r_ev_vld
                        && (r_ev_row == r_f_last[PAGE_W-1 -: ROW_W]);
    assign w_out_free = !r_out_vld || i_m_tready;

    // read-modify-write of one word over the run
    assign w_we   = (r_state == S_FILL) && r_ev_vld;
    assign w_lo_b = (r_ev_row == r_f_start[PAGE_W-1 -: ROW_W]) ? r_f_start[BIT_W-1:0] : '0;
    assign w_hi_b = (r_ev_row == r_f_last[PAGE_W-1 -: ROW_W]) ? r_f_last[BIT_W-1:0] : '1;
    assign w_mask = ({WORD_W{1'b1}} << w_lo_b)
                    & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - w_hi_b));
    assign w_wdata = r_f_val ? (w_word | w_mask) : (w_word & ~w_mask);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_mode)
                        MODE_ALLOC: n_state = (w_in_count == '0) ? S_RESP : S_SCAN;
                        MODE_FREE, MODE_MARK: begin
                            n_state = (w_in_count == '0) ? S_RESP : S_FILL;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_scan_hit) begin
                    n_state = S_FILL;
                end else if (w_scan_end && !w_retry) begin
                    n_state = S_RESP;
                end
            end
            S_FILL: begin
                if (w_fill_end) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ptr     <= '0;
            r_row_vld <= '0;
            r_out_vld <= 1'b0;
            r_ev_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ev_vld <= ((r_state == S_SCAN) && (n_state == S_SCAN) && !w_retry)
                        || ((r_state == S_FILL) && (n_state == S_FILL));
            if (w_we) begin
                r_row_vld[r_ev_row] <= 1'b1;
            end
            // pointer: zero on a zero-page allocate, at or past the map end, or on retry
            if (w_accept && (w_mode == MODE_ALLOC)
                && ((w_in_count == '0) || r_ptr[CNT_W-1])) begin
                r_ptr <= '0;
            end else if (w_retry) begin
                r_ptr <= '0;
            end else if (w_fill_end && r_is_alloc) begin
                r_ptr <= {1'b0, r_f_last} + CNT_W'(1);
            end
            if (o_m_tvalid && i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            if ((r_state == S_RESP) && w_out_free) begin
                r_out_vld <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_q_vld  <= r_row_vld[r_rd_row];
        r_ev_row <= r_rd_row;
        if ((r_state == S_SCAN) || (r_state == S_FILL)) begin
            r_rd_row <= r_rd_row + ROW_W'(1);
        end
        if (w_accept) begin
            r_is_alloc <= (w_mode == MODE_ALLOC);
            r_f_val    <= (w_mode == MODE_MARK);
            r_count    <= w_in_count;
            r_res_ok   <= 1'b0;
            r_res_base <= w_in_start;
            r_res_gr   <= '0;
            r_carry    <= '0;
            r_ev_first <= 1'b1;
            case (w_mode)
                MODE_ALLOC: begin
                    if (w_in_count == '0) begin
                        r_res_ok   <= 1'b1;
                        r_res_base <= '0;
                    end
                    if (r_ptr[CNT_W-1]) begin
                        r_rd_row <= '0;
                        r_lo     <= '0;
                    end else begin
                        r_rd_row <= r_ptr[PAGE_W-1 -: ROW_W];
                        r_lo     <= r_ptr[BIT_W-1:0];
                    end
                end
                MODE_FREE, MODE_MARK: begin
                    r_res_ok  <= 1'b1;
                    r_res_gr  <= w_in_gr;
                    r_f_start <= w_in_start;
                    r_f_last  <= w_in_last[PAGE_W-1:0];
                    r_rd_row  <= w_in_start[PAGE_W-1 -: ROW_W];
                end
                default: ;
            endcase
        end
        if ((r_state == S_SCAN) && r_ev_vld) begin
            r_ev_first <= 1'b0;
            r_carry    <= w_srch.carry;
            if (w_srch.hit) begin
                r_res_ok   <= 1'b1;
                r_res_base <= w_hit_base[PAGE_W-1:0];
                r_res_gr   <= r_count;
                r_f_start  <= w_hit_base[PAGE_W-1:0];
                r_f_last   <= w_hit_last[PAGE_W-1:0];
                r_f_val    <= 1'b1;
                r_rd_row   <= w_hit_base[PAGE_W-1 -: ROW_W];
            end else if (w_retry) begin
                // restart the search from page zero
                r_rd_row   <= '0;
                r_lo       <= '0;
                r_carry    <= '0;
                r_ev_first <= 1'b1;
            end
        end
        if ((r_state == S_RESP) && w_out_free) begin
            r_out_ok   <= r_res_ok;
            r_out_base <= r_res_base;
            r_out_gr   <= r_res_gr;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = M_TDATA_W'({r_out_gr, r_out_base, r_out_ok});

    // the write row never collides with the row being read
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_rd_row != r_ev_row))
        else $error("map RAM read and write hit the same row");

    // the map is only written while a run is being filled
    a_write_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_FILL))
        else $error("map RAM written outside a fill");

    // the pointer never runs past the map end
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= CNT_W'(NUM_PAGES))
        else $error("next-fit pointer beyond map end");

    // a written row is marked valid
    a_row_vld_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> r_row_vld[$past(r_ev_row)])
        else $error("written row not marked valid");

    // a response leaves the sequencer only when the output register can take it
    a_resp_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RESP) && r_out_vld && !i_m_tready) |=> (r_state == S_RESP))
        else $error("response dropped while output stalled");

endmodule

`default_nettype wire
